FILE: design/optb_pkg.sv
// package for the oneshot/periodic timer bank
// holds command and status codes, default sizes and the control word passed along the cell row
// no dependencies
`default_nettype none

package optb_pkg;

	localparam int NUM_TIMERS_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int NUM_RATES_DEF   = 4;

	// width used to compare a timer index against a cell number or the bank size
	localparam int IDX_CMP_W = 7;
	// width used to compare a rate against the number of rates
	localparam int RATE_CMP_W = 5;

	typedef enum logic [2:0] {
		OP_ARM    = 3'd0,
		OP_DISARM = 3'd1,
		OP_REARM  = 3'd2,
		OP_CHECK  = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_ARMED = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic       valid;
		logic       done;
		op_t        op;
		logic [3:0] idx;
		logic [1:0] rate;
		status_t    status;
		logic       flag;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/optb_cell.sv
// one timer of the bank: count, reload, rate and was-disarmed flag
// acts on the command word passing by and hands it on to the next cell; uses optb_pkg
`default_nettype none

module optb_cell import optb_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int NUM_RATES   = NUM_RATES_DEF,
	parameter int CELL_IDX    = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire cell_ctl_t              ctl_in,
	input  wire logic [COUNT_WIDTH-1:0] ticks_in,
	input  wire logic [COUNT_WIDTH-1:0] ivl_in,
	output cell_ctl_t                   ctl_out,
	output logic      [COUNT_WIDTH-1:0] ticks_out,
	output logic      [COUNT_WIDTH-1:0] ivl_out,
	output logic                        expire
);

	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [COUNT_WIDTH-1:0] reload_q, reload_d;
	logic [1:0]             rate_q, rate_d;
	logic                   dis_q, dis_d;
	cell_ctl_t              ctl_q, ctl_d;
	logic [COUNT_WIDTH-1:0] ticks_q;
	logic [COUNT_WIDTH-1:0] ivl_q;
	logic                   act;
	logic                   hit;
	logic                   running;

	always_comb begin
		ctl_d    = ctl_in;
		count_d  = count_q;
		reload_d = reload_q;
		rate_d   = rate_q;
		dis_d    = dis_q;
		expire   = 1'b0;
		act      = ctl_in.valid && advance && !ctl_in.done;
		hit      = {3'd0, ctl_in.idx} == IDX_CMP_W'(CELL_IDX);
		running  = count_q != '0;
		if (act) begin
			if (ctl_in.op == OP_TICK) begin
				if (running && rate_q == ctl_in.rate) begin
					if (count_q == COUNT_WIDTH'(1)) begin
						count_d = reload_q;
						expire  = 1'b1;
					end else begin
						count_d = count_q - COUNT_WIDTH'(1);
					end
				end
			end else if (hit) begin
				case (ctl_in.op)
					OP_ARM: begin
						if (running) begin
							ctl_d.status = ST_ARMED;
						end else if ({3'd0, ctl_in.rate} >= RATE_CMP_W'(NUM_RATES)) begin
							ctl_d.status = ST_RANGE;
						end else begin
							count_d  = ticks_in;
							reload_d = ivl_in;
							rate_d   = ctl_in.rate;
						end
					end
					OP_DISARM: begin
						if (running) begin
							ctl_d.flag = 1'b1;
							dis_d      = 1'b1;
							count_d    = '0;
						end else begin
							dis_d = 1'b0;
						end
					end
					OP_REARM: begin
						ctl_d.flag = running;
						count_d    = ticks_in;
					end
					OP_CHECK: begin
						ctl_d.flag = dis_q;
						dis_d      = 1'b1;
					end
					default: begin
						ctl_d = ctl_in;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			rate_q   <= '0;
			dis_q    <= 1'b0;
			ctl_q    <= '0;
		end else begin
			count_q  <= count_d;
			reload_q <= reload_d;
			rate_q   <= rate_d;
			dis_q    <= dis_d;
			if (advance) begin
				ctl_q <= ctl_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ticks_q <= ticks_in;
			ivl_q   <= ivl_in;
		end
	end

	assign ctl_out   = ctl_q;
	assign ticks_out = ticks_q;
	assign ivl_out   = ivl_q;

endmodule

`default_nettype wire

FILE: design/oneshot_periodic_timer_bank.sv
// Bank of one-shot / periodic timers built as a row of NUM_TIMERS cells, one timer per cell.
// Each command word enters an entry register and then walks the row one cell per cycle while
// the output is not stalled; the addressed cell answers it, and a tick updates every running
// timer of its rate as it passes. A word passes the entry register and every cell of the row
// before its last result word is loaded into the output register; the next word is taken in
// the cycle after. Expiries leave in timer index order, one result word each, the last one
// marked with tlast; a tick without expiries and every other command give one word. While the
// output is stalled the row stands still. All state is in flip-flops; reset clears the control
// and count state but not the data registers. Depends on optb_pkg and optb_cell.
`default_nettype none

module oneshot_periodic_timer_bank import optb_pkg::*; #(
	parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int NUM_RATES   = NUM_RATES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [3:0] timer_index, [19:4] ticks, [35:20] interval, [37:36] tick_rate, [39:38] zero
	input  wire logic [39:0] s_tdata,
	// [2:0] operation
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [2] answer_flag, [6:3] expired_timer, [7] zero
	output logic [7:0]       m_tdata,
	// [0] expiry_valid
	output logic             m_tuser,
	output logic             m_tlast
);

	localparam logic [32:0] COUNT_LIMIT = (33'd1 << COUNT_WIDTH) - 33'd1;

	cell_ctl_t              chain_ctl   [NUM_TIMERS+1];
	logic [COUNT_WIDTH-1:0] chain_ticks [NUM_TIMERS+1];
	logic [COUNT_WIDTH-1:0] chain_ivl   [NUM_TIMERS+1];
	logic [NUM_TIMERS-1:0]  exp_bits;

	cell_ctl_t              ent_ctl_q, in_ctl;
	logic [COUNT_WIDTH-1:0] ent_ticks_q, ent_ivl_q;
	logic                   busy_q;
	logic                   hold_valid_q;
	logic [3:0]             hold_idx_q;
	logic                   m_valid_q;
	logic [7:0]             m_data_q;
	logic                   m_user_q;
	logic                   m_last_q;

	logic                   accept;
	logic                   advance;
	logic                   exp_any;
	logic [3:0]             exp_idx;
	logic                   push;
	logic                   push_last;
	logic                   push_exp;
	logic [3:0]             push_idx;
	status_t                push_status;
	logic                   push_flag;
	logic                   end_word;

	logic [32:0]            ticks_ext, ivl_ext;
	op_t                    in_op;
	logic [3:0]             in_idx;
	logic [1:0]             in_rate;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign advance  = !m_valid_q || m_tready;

	// front checks that need no timer state
	always_comb begin
		in_op     = op_t'(s_tuser);
		in_idx    = s_tdata[3:0];
		in_rate   = s_tdata[37:36];
		ticks_ext = {17'd0, s_tdata[19:4]};
		ivl_ext   = {17'd0, s_tdata[35:20]};
		in_ctl        = '0;
		in_ctl.valid  = 1'b1;
		in_ctl.op     = in_op;
		in_ctl.idx    = in_idx;
		in_ctl.rate   = in_rate;
		in_ctl.status = ST_OK;
		if (in_op == OP_TICK) begin
			if ({3'd0, in_rate} >= RATE_CMP_W'(NUM_RATES)) begin
				in_ctl.done   = 1'b1;
				in_ctl.status = ST_RANGE;
			end
		end else if (s_tuser > OP_TICK || {3'd0, in_idx} >= IDX_CMP_W'(NUM_TIMERS)) begin
			in_ctl.done   = 1'b1;
			in_ctl.status = ST_RANGE;
		end else begin
			case (in_op)
				OP_ARM: begin
					if (ticks_ext >= COUNT_LIMIT || ivl_ext >= COUNT_LIMIT) begin
						in_ctl.done   = 1'b1;
						in_ctl.status = ST_RANGE;
					end else if (ticks_ext == '0) begin
						in_ctl.done   = 1'b1;
						in_ctl.status = ST_ZERO;
					end
				end
				OP_REARM: begin
					if (ticks_ext >= COUNT_LIMIT) begin
						in_ctl.done   = 1'b1;
						in_ctl.status = ST_RANGE;
					end else if (ticks_ext == '0) begin
						in_ctl.done   = 1'b1;
						in_ctl.status = ST_ZERO;
					end
				end
				default: begin
					in_ctl.done = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_ctl_q <= '0;
		end else if (accept) begin
			ent_ctl_q <= in_ctl;
		end else if (advance) begin
			ent_ctl_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_ticks_q <= ticks_ext[COUNT_WIDTH-1:0];
			ent_ivl_q   <= ivl_ext[COUNT_WIDTH-1:0];
		end
	end

	assign chain_ctl[0]   = ent_ctl_q;
	assign chain_ticks[0] = ent_ticks_q;
	assign chain_ivl[0]   = ent_ivl_q;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		optb_cell #(
			.COUNT_WIDTH (COUNT_WIDTH),
			.NUM_RATES   (NUM_RATES),
			.CELL_IDX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.ctl_in    (chain_ctl[i]),
			.ticks_in  (chain_ticks[i]),
			.ivl_in    (chain_ivl[i]),
			.ctl_out   (chain_ctl[i+1]),
			.ticks_out (chain_ticks[i+1]),
			.ivl_out   (chain_ivl[i+1]),
			.expire    (exp_bits[i])
		);
	end

	// at most one cell acts in a cycle
	always_comb begin
		exp_any = 1'b0;
		exp_idx = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (exp_bits[i]) begin
				exp_any = 1'b1;
				exp_idx = exp_idx | 4'(i);
			end
		end
	end

	assign end_word = advance && chain_ctl[NUM_TIMERS].valid;

	always_comb begin
		push        = 1'b0;
		push_last   = 1'b0;
		push_exp    = 1'b0;
		push_idx    = '0;
		push_status = ST_OK;
		push_flag   = 1'b0;
		if (end_word) begin
			push      = 1'b1;
			push_last = 1'b1;
			if (chain_ctl[NUM_TIMERS].op == OP_TICK && !chain_ctl[NUM_TIMERS].done) begin
				push_exp = hold_valid_q;
				push_idx = hold_valid_q ? hold_idx_q : 4'd0;
			end else begin
				push_status = chain_ctl[NUM_TIMERS].status;
				push_flag   = chain_ctl[NUM_TIMERS].flag;
			end
		end else if (advance && exp_any && hold_valid_q) begin
			push     = 1'b1;
			push_exp = 1'b1;
			push_idx = hold_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (end_word) begin
				busy_q <= 1'b0;
			end
			if (advance && exp_any) begin
				hold_valid_q <= 1'b1;
			end else if (end_word) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && exp_any) begin
			hold_idx_q <= exp_idx;
		end
		if (push) begin
			m_data_q <= {1'b0, push_idx, push_flag, push_status};
			m_user_q <= push_exp;
			m_last_q <= push_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

`default_nettype wire

FILE: design/optb_checker.sv
// port-level checks for the oneshot/periodic timer bank
// bound to oneshot_periodic_timer_bank; sees its ports only
`default_nettype none

module optb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [39:0] s_tdata,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output word changed");

	// one command in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in flight");

	// a word without expiry is always the only or final word
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[6:3] == 4'd0)
		else $error("non-expiry word not last or carries a timer index");

	// expiry words carry ok status and no answer flag
	a_exp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0 && !m_tdata[7])
		else $error("expiry word with status or flag set");

	// input not ready while a result word other than the last one is valid
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while a tick still reports expiries");

endmodule

bind oneshot_periodic_timer_bank optb_checker u_optb_checker (.*);

`default_nettype wire
